// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL files; the register master includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside of reset.
`define ASSERT_CLKRST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLKRST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

// ----- sv/bbtw_pkg.sv -----
package bbtw_pkg;

    localparam int unsigned StepW = 7;

    localparam logic [StepW-1:0] START_LEN = 7'd3;
    localparam logic [StepW-1:0] BYTE_LEN  = 7'd27;
    localparam logic [StepW-1:0] READ_LEN  = 7'd20;
    localparam logic [StepW-1:0] STOP_LEN  = 7'd3;

    localparam logic [StepW-1:0] WRITE_TOTAL = START_LEN + 7'd3 * BYTE_LEN + STOP_LEN;
    localparam logic [StepW-1:0] READ_TOTAL  =
        START_LEN + 7'd2 * BYTE_LEN + READ_LEN + STOP_LEN;

    localparam logic [StepW-1:0] ADDR_AT     = START_LEN;
    localparam logic [StepW-1:0] REG_AT      = START_LEN + BYTE_LEN;
    localparam logic [StepW-1:0] DATA_AT     = START_LEN + 7'd2 * BYTE_LEN;
    localparam logic [StepW-1:0] RD_STOP_AT  = DATA_AT + READ_LEN;
    localparam logic [StepW-1:0] WR_STOP_AT  = DATA_AT + BYTE_LEN;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drive;
    } pins_t;

    typedef struct packed {
        logic       is_read;
        logic       reg_select;
        logic [7:0] data;
    } request_t;

endpackage

// ----- sv/bitbang_two_wire_register_master.sv -----
// Two-wire register master that advances its clock and data pins by one
// step for every input beat taken during a transfer.
// The input channel (s_valid/s_ready) carries one tick per beat: a start
// request with its read flag, register select and write byte, and the level
// sampled on the data pin. A start request is taken only while idle.
// The result channel (m_valid/m_ready) returns exactly one beat per input
// beat: the clock level, the data level and its drive enable, busy, done on
// the last step, and the receive shift register.
// The result beat is registered and appears in the cycle after its input
// beat is taken; a beat is accepted every cycle while the receiver keeps
// up. A write takes 87 beats and a read 80. When the receiver stalls, the
// result register holds and s_ready drops, so the pin sequence stops where
// it is until the result is taken. Reset (aresetn low at a clock edge)
// returns the block to idle with both pins driven high, clears the slave
// address and the receive register. The slave address is written through
// cfg_wr_en/cfg_wr_data; the user must do so while idle, as no logic checks.
module bitbang_two_wire_register_master
    import bbtw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_start_request,
    input  logic       s_is_read,
    input  logic       s_reg_select,
    input  logic [7:0] s_write_data,
    input  logic       s_sda_in,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl,
    output logic       m_sda_out,
    output logic       m_sda_drive,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_data
);

    logic [6:0]       slave_addr_reg;
    logic             active_reg;
    logic [StepW-1:0] step_count_reg;
    pins_t            pins_reg;
    request_t         req_reg;
    logic [7:0]       shift_reg;

    logic             m_valid_reg;
    pins_t            m_pins_reg;
    logic             m_busy_reg;
    logic             m_done_reg;
    logic [7:0]       m_read_data_reg;

    logic             accept;
    logic             start_new;
    logic             run;
    request_t         req_cur;
    logic [StepW-1:0] step_cur;
    logic [StepW-1:0] total;
    logic             last;
    pins_t            step_pins;
    logic [7:0]       shift_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign start_new = !active_reg && s_start_request;
    assign run       = active_reg || s_start_request;
    assign req_cur   = start_new ? request_t'{is_read: s_is_read, reg_select: s_reg_select,
                                              data: s_write_data} : req_reg;
    assign step_cur  = start_new ? '0 : step_count_reg;
    assign total     = req_cur.is_read ? READ_TOTAL : WRITE_TOTAL;
    assign last      = ({1'b0, step_cur} + 8'd1) >= {1'b0, total};

    bbtw_step u_step (
        .step          (step_cur),
        .req           (req_cur),
        .slave_address (slave_addr_reg),
        .hold_sda      (pins_reg.sda),
        .shift_in      (shift_reg),
        .sda_in        (s_sda_in),
        .pins          (step_pins),
        .shift_out     (shift_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= '0;
            active_reg     <= 1'b0;
            step_count_reg <= '0;
            pins_reg       <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
            req_reg        <= '0;
            shift_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slave_addr_reg <= cfg_wr_data;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
                if (run) begin
                    req_reg        <= req_cur;
                    pins_reg       <= step_pins;
                    shift_reg      <= shift_next;
                    active_reg     <= !last;
                    step_count_reg <= last ? '0 : step_cur + 7'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_pins_reg      <= run ? step_pins : pins_reg;
            m_busy_reg      <= run;
            m_done_reg      <= run && last;
            m_read_data_reg <= run ? shift_next : shift_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl       = m_pins_reg.scl;
    assign m_sda_out   = m_pins_reg.sda;
    assign m_sda_drive = m_pins_reg.drive;
    assign m_busy_res  = m_busy_reg;
    assign m_done_res  = m_done_reg;
    assign m_read_data = m_read_data_reg;

`include "assert_macros.svh"

    `ASSERT_CLKRST(a_step_in_range, aclk, aresetn, step_count_reg < WRITE_TOTAL)
    `ASSERT_CLKRST(a_idle_step_zero, aclk, aresetn, !active_reg |-> step_count_reg == '0)
    `ASSERT_CLKRST(a_done_ends_run, aclk, aresetn, (accept && run && last) |=> !active_reg)
    `ASSERT_CLKRST(a_hold_when_stalled, aclk, aresetn, !accept |=> $stable(active_reg) && $stable(step_count_reg))
    `ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> (!active_reg && !m_valid_reg))

endmodule

// ----- sv/bbtw_step.sv -----
module bbtw_step
    import bbtw_pkg::*;
(
    input  logic [StepW-1:0] step,
    input  request_t         req,
    input  logic [6:0]       slave_address,
    input  logic             hold_sda,
    input  logic [7:0]       shift_in,
    input  logic             sda_in,
    output pins_t            pins,
    output logic [7:0]       shift_out
);

    // One step of a sent byte: a clock-low step holding data, eight bits of
    // three steps each, then the released acknowledge slot.
    function automatic pins_t send_pins(input logic [7:0] b, input logic [4:0] k,
                                        input logic hold);
        pins_t      p;
        logic [4:0] km1;
        logic [2:0] bit_idx;
        logic [4:0] ph;
        km1     = k - 5'd1;
        bit_idx = '0;
        for (int j = 1; j < 8; j++) begin
            if (km1 >= 5'(3 * j)) begin
                bit_idx = 3'(j);
            end
        end
        ph = km1 - 5'(3 * bit_idx);
        if (k == 5'd0) begin
            p = '{scl: 1'b0, sda: hold, drive: 1'b1};
        end else if (k <= 5'd24) begin
            p = '{scl: (ph == 5'd1), sda: b[3'd7 - bit_idx], drive: 1'b1};
        end else if (k == 5'd25) begin
            p = '{scl: 1'b0, sda: hold, drive: 1'b0};
        end else begin
            p = '{scl: 1'b1, sda: hold, drive: 1'b0};
        end
        return p;
    endfunction

    function automatic pins_t stop_pins(input logic [StepW-1:0] t);
        pins_t p;
        if (t == '0) begin
            p = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
        end else if (t == 7'd1) begin
            p = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
        end else begin
            p = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
        end
        return p;
    endfunction

    logic [7:0]       addr_byte;
    logic [7:0]       reg_byte;
    logic [StepW-1:0] k_addr;
    logic [StepW-1:0] k_reg;
    logic [StepW-1:0] k_data;
    logic [StepW-1:0] t_rd_stop;
    logic [StepW-1:0] t_wr_stop;
    logic [4:0]       k_rd;

    assign addr_byte = {slave_address, req.is_read};
    assign reg_byte  = {7'd0, req.reg_select};
    assign k_addr    = step - ADDR_AT;
    assign k_reg     = step - REG_AT;
    assign k_data    = step - DATA_AT;
    assign t_rd_stop = step - RD_STOP_AT;
    assign t_wr_stop = step - WR_STOP_AT;
    assign k_rd      = k_data[4:0];

    always_comb begin
        shift_out = shift_in;
        pins      = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
        if (step < ADDR_AT) begin
            case (step[1:0])
                2'd0:    pins = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
                2'd1:    pins = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
                default: pins = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
            endcase
        end else if (step < REG_AT) begin
            pins = send_pins(addr_byte, k_addr[4:0], hold_sda);
        end else if (step < DATA_AT) begin
            pins = send_pins(reg_byte, k_reg[4:0], hold_sda);
        end else if (req.is_read) begin
            if (step < RD_STOP_AT) begin
                if (k_rd == 5'd0) begin
                    shift_out = '0;
                    pins      = '{scl: 1'b0, sda: hold_sda, drive: 1'b0};
                end else if (k_rd <= 5'd16) begin
                    if (k_rd[0]) begin
                        pins      = '{scl: 1'b1, sda: hold_sda, drive: 1'b0};
                        shift_out = {shift_in[6:0], sda_in};
                    end else begin
                        pins = '{scl: 1'b0, sda: hold_sda, drive: 1'b0};
                    end
                end else if (k_rd == 5'd18) begin
                    pins = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
                end else begin
                    pins = '{scl: 1'b0, sda: 1'b1, drive: 1'b1};
                end
            end else begin
                pins = stop_pins(t_rd_stop);
            end
        end else if (step < WR_STOP_AT) begin
            pins = send_pins(req.data, k_data[4:0], hold_sda);
        end else begin
            pins = stop_pins(t_wr_stop);
        end
    end

endmodule
